/* src/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, quiet while reset is high.
`define PIC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("pic assertion failed");

// Checked at every rising edge, reset included.
`define PIC_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("pic assertion failed");

`endif

/* src/pic_pkg.sv */
`default_nettype none

package pic_pkg;

   localparam int SAMPLE_W = 12;
   localparam int GAIN_W   = 16;
   localparam int BOUND_W  = 29;
   localparam int DUTY_W   = 16;
   localparam int INTEG_W  = 30;
   localparam int PROD_W   = GAIN_W + SAMPLE_W;   // 28
   localparam int TERM_W   = PROD_W + 1;          // signed difference of two products
   localparam int SUM_W    = INTEG_W + 1;         // integrator plus a term, full precision
   localparam int SHIFT    = 16;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;

   // register indexes
   localparam logic [2:0] REG_SETPOINT    = 3'd0;
   localparam logic [2:0] REG_KI_SP       = 3'd1;
   localparam logic [2:0] REG_KI_ADC      = 3'd2;
   localparam logic [2:0] REG_KP_SP       = 3'd3;
   localparam logic [2:0] REG_KP_ADC      = 3'd4;
   localparam logic [2:0] REG_INTEG_BOUND = 3'd5;
   localparam logic [2:0] REG_DUTY_UPPER  = 3'd6;
   localparam logic [2:0] REG_DUTY_LOWER  = 3'd7;

   // reset values
   localparam logic [SAMPLE_W-1:0] RST_SETPOINT    = 12'd0;
   localparam logic [GAIN_W-1:0]   RST_KI_SP       = 16'd569;
   localparam logic [GAIN_W-1:0]   RST_KI_ADC      = 16'd9;
   localparam logic [GAIN_W-1:0]   RST_KP_SP       = 16'd27314;
   localparam logic [GAIN_W-1:0]   RST_KP_ADC      = 16'd440;
   localparam logic [BOUND_W-1:0]  RST_INTEG_BOUND = 29'd50000000;
   localparam logic [DUTY_W-1:0]   RST_DUTY_UPPER  = 16'd400;
   localparam logic [DUTY_W-1:0]   RST_DUTY_LOWER  = 16'd110;

   typedef struct packed {
      logic [SAMPLE_W-1:0] setpoint;
      logic [GAIN_W-1:0]   ki_sp;
      logic [GAIN_W-1:0]   ki_adc;
      logic [GAIN_W-1:0]   kp_sp;
      logic [GAIN_W-1:0]   kp_adc;
      logic [BOUND_W-1:0]  integ_bound;
      logic [DUTY_W-1:0]   duty_upper;
      logic [DUTY_W-1:0]   duty_lower;
   } cfg_type;

   // one queued item: integrator increment and proportional term
   typedef struct packed {
      logic [TERM_W-1:0] term_i;
      logic [TERM_W-1:0] term_p;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

/* src/pic_csr.sv */
`default_nettype none

module pic_csr (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [pic_pkg::ADDR_W-1:0] paddr,
   input  wire logic [pic_pkg::DATA_W-1:0] pwdata,
   output logic      [pic_pkg::DATA_W-1:0] prdata,
   output logic                           pready,
   output pic_pkg::cfg_type               cfg
);

   pic_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]       index;
   logic             wr_en;

   assign pready = 1'b1;
   assign index  = paddr[4:2];
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            pic_pkg::REG_SETPOINT:    cfg_in.setpoint    = pwdata[pic_pkg::SAMPLE_W-1:0];
            pic_pkg::REG_KI_SP:       cfg_in.ki_sp       = pwdata[pic_pkg::GAIN_W-1:0];
            pic_pkg::REG_KI_ADC:      cfg_in.ki_adc      = pwdata[pic_pkg::GAIN_W-1:0];
            pic_pkg::REG_KP_SP:       cfg_in.kp_sp       = pwdata[pic_pkg::GAIN_W-1:0];
            pic_pkg::REG_KP_ADC:      cfg_in.kp_adc      = pwdata[pic_pkg::GAIN_W-1:0];
            pic_pkg::REG_INTEG_BOUND: cfg_in.integ_bound = pwdata[pic_pkg::BOUND_W-1:0];
            pic_pkg::REG_DUTY_UPPER:  cfg_in.duty_upper  = pwdata[pic_pkg::DUTY_W-1:0];
            pic_pkg::REG_DUTY_LOWER:  cfg_in.duty_lower  = pwdata[pic_pkg::DUTY_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         pic_pkg::REG_SETPOINT:    prdata = {20'd0, cfg_ff.setpoint};
         pic_pkg::REG_KI_SP:       prdata = {16'd0, cfg_ff.ki_sp};
         pic_pkg::REG_KI_ADC:      prdata = {16'd0, cfg_ff.ki_adc};
         pic_pkg::REG_KP_SP:       prdata = {16'd0, cfg_ff.kp_sp};
         pic_pkg::REG_KP_ADC:      prdata = {16'd0, cfg_ff.kp_adc};
         pic_pkg::REG_INTEG_BOUND: prdata = {3'd0, cfg_ff.integ_bound};
         pic_pkg::REG_DUTY_UPPER:  prdata = {16'd0, cfg_ff.duty_upper};
         pic_pkg::REG_DUTY_LOWER:  prdata = {16'd0, cfg_ff.duty_lower};
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint    <= pic_pkg::RST_SETPOINT;
         cfg_ff.ki_sp       <= pic_pkg::RST_KI_SP;
         cfg_ff.ki_adc      <= pic_pkg::RST_KI_ADC;
         cfg_ff.kp_sp       <= pic_pkg::RST_KP_SP;
         cfg_ff.kp_adc      <= pic_pkg::RST_KP_ADC;
         cfg_ff.integ_bound <= pic_pkg::RST_INTEG_BOUND;
         cfg_ff.duty_upper  <= pic_pkg::RST_DUTY_UPPER;
         cfg_ff.duty_lower  <= pic_pkg::RST_DUTY_LOWER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* src/pic_front.sv */
`default_nettype none

// Accepts a sample and forms both gain differences for the back end.
module pic_front (
   input  wire logic                        req_valid,
   input  wire logic [pic_pkg::SAMPLE_W-1:0] req_adc_sample,
   input  wire pic_pkg::cfg_type            cfg,
   input  wire pic_pkg::q_status_type       q_status,
   output logic                             req_stall,
   output logic                             push,
   output pic_pkg::entry_type               entry
);

   localparam int PROD_W = pic_pkg::PROD_W;

   logic [PROD_W-1:0] ki_sp_prod, ki_adc_prod, kp_sp_prod, kp_adc_prod;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      ki_sp_prod   = PROD_W'(cfg.ki_sp)  * PROD_W'(cfg.setpoint);
      ki_adc_prod  = PROD_W'(cfg.ki_adc) * PROD_W'(req_adc_sample);
      kp_sp_prod   = PROD_W'(cfg.kp_sp)  * PROD_W'(cfg.setpoint);
      kp_adc_prod  = PROD_W'(cfg.kp_adc) * PROD_W'(req_adc_sample);
      entry.term_i = {1'b0, ki_sp_prod} - {1'b0, ki_adc_prod};
      entry.term_p = {1'b0, kp_sp_prod} - {1'b0, kp_adc_prod};
   end

endmodule

`default_nettype wire

/* src/pic_queue.sv */
`default_nettype none

module pic_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire pic_pkg::entry_type   push_entry,
   input  wire logic                 pop,
   output pic_pkg::entry_type        head,
   output pic_pkg::q_status_type     q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   pic_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head           = mem_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* src/pic_back.sv */
`default_nettype none

// Integrator update with clamp, then duty sum, shift and clamp.
module pic_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire pic_pkg::cfg_type               cfg,
   input  wire pic_pkg::q_status_type          q_status,
   input  wire pic_pkg::entry_type             head,
   output logic                                pop,
   input  wire logic                           rsp_stall,
   output logic                                rsp_valid,
   output logic [pic_pkg::DUTY_W-1:0]          rsp_duty,
   output logic signed [pic_pkg::INTEG_W-1:0]  rsp_integ_value
);

   localparam int SUM_W  = pic_pkg::SUM_W;
   localparam int INT_W  = pic_pkg::INTEG_W;
   localparam int TERM_W = pic_pkg::TERM_W;
   localparam int SH_W   = SUM_W - pic_pkg::SHIFT;
   localparam int CMP_W  = pic_pkg::DUTY_W + 1;

   logic signed [INT_W-1:0]  integ_ff, integ_in;
   logic                     mid_valid_ff, mid_valid_in;
   logic signed [INT_W-1:0]  mid_integ_ff;
   logic [TERM_W-1:0]        mid_term_p_ff;
   logic                     out_valid_ff, out_valid_in;
   logic [pic_pkg::DUTY_W-1:0] out_duty_ff, out_duty_in;
   logic signed [INT_W-1:0]  out_integ_ff;

   logic signed [SUM_W-1:0]  acc, bound_pos, bound_neg, acc_clamped;
   logic signed [SUM_W-1:0]  duty_sum;
   logic signed [SH_W-1:0]   duty_sh;
   logic signed [CMP_W-1:0]  duty_ext, upper_ext, lower_ext, duty_hi;
   logic                     out_ready, mid_ready, mid_advance;

   assign out_ready   = !out_valid_ff || !rsp_stall;
   assign mid_ready   = !mid_valid_ff || out_ready;
   assign mid_advance = mid_valid_ff && out_ready;
   assign pop         = !q_status.empty && mid_ready;

   // integrator loop: one add and a two-sided clamp
   always_comb begin
      acc       = $signed({integ_ff[INT_W-1], integ_ff})
                + $signed({{(SUM_W-TERM_W){head.term_i[TERM_W-1]}}, head.term_i});
      bound_pos = $signed({{(SUM_W-pic_pkg::BOUND_W){1'b0}}, cfg.integ_bound});
      bound_neg = -bound_pos;
      acc_clamped = acc;
      if (acc > bound_pos) begin
         acc_clamped = bound_pos;
      end
      if (acc_clamped < bound_neg) begin
         acc_clamped = bound_neg;
      end
      integ_in = pop ? acc_clamped[INT_W-1:0] : integ_ff;
   end

   // duty: floor shift by taking the high bits, upper clamp then lower clamp
   always_comb begin
      duty_sum  = $signed({mid_integ_ff[INT_W-1], mid_integ_ff})
                + $signed({{(SUM_W-TERM_W){mid_term_p_ff[TERM_W-1]}}, mid_term_p_ff});
      duty_sh   = duty_sum[SUM_W-1:pic_pkg::SHIFT];
      duty_ext  = $signed({{(CMP_W-SH_W){duty_sh[SH_W-1]}}, duty_sh});
      upper_ext = $signed({1'b0, cfg.duty_upper});
      lower_ext = $signed({1'b0, cfg.duty_lower});
      duty_hi   = (duty_ext > upper_ext) ? upper_ext : duty_ext;
      out_duty_in = (duty_hi < lower_ext) ? cfg.duty_lower : duty_hi[pic_pkg::DUTY_W-1:0];
   end

   always_comb begin
      if (pop) begin
         mid_valid_in = 1'b1;
      end else if (out_ready) begin
         mid_valid_in = 1'b0;
      end else begin
         mid_valid_in = mid_valid_ff;
      end
      if (mid_advance) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff     <= '0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         integ_ff     <= integ_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         mid_integ_ff  <= acc_clamped[INT_W-1:0];
         mid_term_p_ff <= head.term_p;
      end
      if (mid_advance) begin
         out_duty_ff  <= out_duty_in;
         out_integ_ff <= mid_integ_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_duty        = out_duty_ff;
   assign rsp_integ_value = out_integ_ff;

endmodule

`default_nettype wire

/* src/pi_current_controller_core.sv */
`default_nettype none

// PI current regulator with anti-windup clamp.
// req channel: one 12-bit ADC sample per item (req_valid / req_stall).
// rsp channel: one item per sample, the clamped duty and the integrator
//   value after that step (rsp_valid / rsp_stall).
// Config: APB-style port, eight registers at byte addresses 0,4,..,28;
//   the user writes them only while no item is in flight (not enforced).
//   pready is tied high. Samples pass the queue, middle and output stages.
// Throughput: one item per cycle while rsp_stall is low. The integrator
//   loop is a single add plus clamp, registered as each item leaves the queue.
// Reset (synchronous): gains and bounds take their default values, the
//   integrator clears to zero, queue and output stages empty.
// Receiver stall: the result holds in the output register, the middle
//   stage and the QUEUE_DEPTH-entry queue take samples until they fill, and
//   req_stall rises only once the queue is full.
module pi_current_controller_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input samples
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [pic_pkg::SAMPLE_W-1:0]        req_adc_sample,
   // results
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [pic_pkg::DUTY_W-1:0]               rsp_duty,
   output logic signed [pic_pkg::INTEG_W-1:0]       rsp_integ_value,
   // configuration
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [pic_pkg::ADDR_W-1:0]          paddr,
   input  wire logic [pic_pkg::DATA_W-1:0]          pwdata,
   output logic [pic_pkg::DATA_W-1:0]               prdata,
   output logic                                     pready
);

   pic_pkg::cfg_type      cfg;
   pic_pkg::entry_type    push_entry, head;
   pic_pkg::q_status_type q_status;
   logic                  push, pop;

   pic_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // front: gain products of the sample, pushed as one queue entry
   pic_front u_front (
      .req_valid      (req_valid),
      .req_adc_sample (req_adc_sample),
      .cfg            (cfg),
      .q_status       (q_status),
      .req_stall      (req_stall),
      .push           (push),
      .entry          (push_entry)
   );

   pic_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   // back: integrator, duty arithmetic, output register
   pic_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .q_status        (q_status),
      .head            (head),
      .pop             (pop),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_duty        (rsp_duty),
      .rsp_integ_value (rsp_integ_value)
   );

endmodule

`default_nettype wire

/* src/pic_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module pic_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_stall,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [pic_pkg::DUTY_W-1:0]          rsp_duty,
   input wire logic signed [pic_pkg::INTEG_W-1:0]  rsp_integ_value
);

   localparam logic [pic_pkg::INTEG_W-1:0] INTEG_MIN = {1'b1, {(pic_pkg::INTEG_W-1){1'b0}}};

   // output register holds a stalled result
   `PIC_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> $stable({rsp_valid, rsp_duty, rsp_integ_value}))

   // nothing comes out of the cycle after reset
   `PIC_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)

   // the clamp is symmetric, so the most negative code never appears
   `PIC_ASSERT(a_integ_range, rsp_valid |-> rsp_integ_value != INTEG_MIN)

   // the queue only fills while the output was held
   `PIC_ASSERT(a_stall_cause, req_stall && !$past(reset) |-> $past(rsp_valid && rsp_stall))

endmodule

bind pi_current_controller_core pic_checker u_pic_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_duty        (rsp_duty),
   .rsp_integ_value (rsp_integ_value)
);

`default_nettype wire
